### rtl/clpg_pkg.sv
// ----------------------------------------------------------------------------
// clpg_pkg: shared types and constants of the cam lift profile generator
// opcodes, sequencer states, fixed-point constants, status codes
// ----------------------------------------------------------------------------
`default_nettype none
package clpg_pkg;

  localparam int NUM_HARMONICS_DEF = 20;
  localparam int NUM_SAMPLES_DEF   = 360;

  localparam logic [31:0] STROKE_RESET = 32'd655360;
  localparam logic [31:0] PI_Q30       = 32'd3373259426;
  localparam logic [31:0] ONE_Q16      = 32'd65536;

  typedef enum logic [1:0] {
    OP_CLEAR   = 2'd0,
    OP_LOAD    = 2'd1,
    OP_COMPUTE = 2'd2,
    OP_READ    = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_RANGE   = 2'd1,
    ST_NOVALID = 2'd2
  } status_t;

  // top sequencer
  typedef enum logic [3:0] {
    S_IDLE,
    S_CSUM,      // any-nonzero coefficient check for fallback
    S_SIN_X,     // start sine of sample i
    S_SIN_WAIT,
    S_HARM,      // one harmonic per pass
    S_STORE,
    S_RD_MEM,
    S_RD_MUL,
    S_RD_DIV,
    S_OUT
  } state_t;

  // reciprocals of (2n)(2n+1) for n = 1..8, ceil(2^shift / d)
  // exact floor division for any 32-bit numerator
  function automatic logic [32:0] taylor_recip(input logic [2:0] n_m1);
    logic [32:0] r;
    unique case (n_m1)
      3'd0: r = 33'd5726623062;
      3'd1: r = 33'd6871947674;
      3'd2: r = 33'd6544712071;
      3'd3: r = 33'd7635497416;
      3'd4: r = 33'd4997780127;
      3'd5: r = 33'd7048151461;
      3'd6: r = 33'd5235769657;
      default: r = 33'd8084644322;
    endcase
    return r;
  endfunction

  // matching right shift, 32 + ceil(log2(d))
  function automatic logic [5:0] taylor_shift(input logic [2:0] n_m1);
    logic [5:0] r;
    unique case (n_m1)
      3'd0: r = 6'd35;
      3'd1: r = 6'd37;
      3'd2: r = 6'd38;
      3'd3: r = 6'd39;
      3'd4: r = 6'd39;
      3'd5: r = 6'd40;
      3'd6: r = 6'd40;
      default: r = 6'd41;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

### rtl/cam_lift_profile_generator_core.sv
// ----------------------------------------------------------------------------
// cam_lift_profile_generator_core: harmonic cam lift profile generator
// coefficient load, profile compute, scaled sample read over one multiplier
// ----------------------------------------------------------------------------
// latency: clear and load offer the result in the cycle after acceptance; a read
// passes S_RD_MEM, two multiply phases and the 73-bit divider; a status,
// edge-sample or zero-peak read goes from S_RD_MEM straight to S_OUT; compute
// runs the sine unit and then one harmonic step per cycle for every sample
// throughput: one transaction at a time, s_axis_tready low while busy
// reset: synchronous, clears coefficients, peak, valid and fallback flags,
// stroke to 10.0; the sample ram is not cleared
`default_nettype none
module cam_lift_profile_generator_core
  import clpg_pkg::*;
#(
  parameter int NUM_HARMONICS = NUM_HARMONICS_DEF,
  parameter int NUM_SAMPLES   = NUM_SAMPLES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // stroke register write
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [31:0] cfg_data,
  // input: opcode[1:0], coef_index[6:2], coef_value[38:7], sample_index[48:39]
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [55:0] s_axis_tdata,
  // output: sample_value[31:0], peak_value[71:32], status[73:72],
  // fallback_used[74]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [79:0] m_axis_tdata
);
  localparam int HW = $clog2(NUM_HARMONICS);
  localparam int SW = $clog2(NUM_SAMPLES);

  state_t state, state_next;

  // captured request
  logic [9:0]  sidx;

  logic [31:0] stroke;
  logic [31:0] coef [NUM_HARMONICS];
  logic [39:0] peak_lift;
  logic        profile_valid;
  logic        fallback_flag;

  // compute datapath
  logic [SW-1:0] si;
  logic [HW-1:0] k;
  logic [15:0]   s;
  logic [15:0]   p;
  logic [39:0]   lift, peak_run;
  logic          nz;
  logic          coef_any;
  logic          sin_start, sin_busy;
  logic [15:0]   sin_out;
  logic [31:0]   ak;
  logic [47:0]   term_prod;
  logic [31:0]   pow_prod;

  // ram
  logic          ram_we;
  logic [SW-1:0] ram_addr;
  logic [39:0]   ram_rdata;

  // read datapath
  logic [71:0]   scaled;
  logic          div_start, div_busy;
  logic [72:0]   div_q;
  logic          phase;

  // output register
  logic [31:0]   o_value;
  logic [1:0]    o_status;

  assign cfg_ready     = (state == S_IDLE) && !m_axis_tvalid;
  assign s_axis_tready = (state == S_IDLE) && !m_axis_tvalid && !cfg_valid;

  // coefficient with fallback of 1.0 on the second harmonic
  assign ak = (!nz && k == HW'(1)) ? ONE_Q16 : coef[k];
  assign term_prod = ak * p;
  assign pow_prod  = p * s;

  // any nonzero coefficient disables the fallback
  always_comb begin
    coef_any = 1'b0;
    for (int h = 0; h < NUM_HARMONICS; h++) begin
      coef_any = coef_any | (coef[h] != '0);
    end
  end

  clpg_sine #(.NUM_SAMPLES(NUM_SAMPLES)) u_sine (
    .clk   (clk),
    .rst   (rst),
    .start (sin_start),
    .idx   (si),
    .busy  (sin_busy),
    .sine  (sin_out)
  );

  clpg_ram #(.WIDTH(40), .DEPTH(NUM_SAMPLES)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (lift),
    .rdata (ram_rdata)
  );

  clpg_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ({1'b0, scaled}),
    .divisor  ({24'd0, peak_lift}),
    .busy     (div_busy),
    .quotient (div_q)
  );

  // read address presented at acceptance so the data is there in S_RD_MEM
  assign ram_we    = (state == S_STORE);
  assign ram_addr  = (state == S_STORE) ? si :
                     (state == S_IDLE)  ? s_axis_tdata[39+SW-1:39] : sidx[SW-1:0];
  assign sin_start = (state == S_SIN_X);
  assign div_start = (state == S_RD_DIV) && phase;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (s_axis_tvalid && s_axis_tready) begin
          unique case (opcode_t'(s_axis_tdata[1:0]))
            OP_COMPUTE: state_next = S_CSUM;
            OP_READ:    state_next = S_RD_MEM;
            default:    state_next = S_OUT;
          endcase
        end
      end
      S_CSUM:     state_next = S_SIN_X;
      S_SIN_X:    state_next = S_SIN_WAIT;
      S_SIN_WAIT: if (!sin_busy) state_next = S_HARM;
      S_HARM:     if (k == HW'(NUM_HARMONICS - 1)) state_next = S_STORE;
      S_STORE:    state_next = (si == SW'(NUM_SAMPLES - 1)) ? S_OUT : S_SIN_X;
      S_RD_MEM: begin
        if ({1'b0, sidx} >= 11'(NUM_SAMPLES) || !profile_valid || sidx == 10'd0 ||
            sidx == 10'(NUM_SAMPLES - 1) || peak_lift == '0) begin
          state_next = S_OUT;
        end else begin
          state_next = S_RD_MUL;
        end
      end
      S_RD_MUL:   if (phase) state_next = S_RD_DIV;
      S_RD_DIV:   if (!div_busy && !div_start) state_next = S_OUT;
      S_OUT:      if (m_axis_tready) state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      stroke        <= STROKE_RESET;
      peak_lift     <= '0;
      profile_valid <= 1'b0;
      fallback_flag <= 1'b0;
      for (int h = 0; h < NUM_HARMONICS; h++) begin
        coef[h] <= '0;
      end
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        stroke <= cfg_data;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        sidx     <= s_axis_tdata[48:39];
        o_value  <= '0;
        o_status <= ST_OK;
        unique case (opcode_t'(s_axis_tdata[1:0]))
          OP_CLEAR: begin
            for (int h = 0; h < NUM_HARMONICS; h++) begin
              coef[h] <= '0;
            end
          end
          OP_LOAD: begin
            if ({1'b0, s_axis_tdata[6:2]} >= 6'(NUM_HARMONICS)) begin
              o_status <= ST_RANGE;
            end else begin
              coef[s_axis_tdata[2+HW-1:2]] <= s_axis_tdata[38] ? '0 : s_axis_tdata[38:7];
            end
          end
          default: ;
        endcase
      end
      if (state == S_STORE && si == SW'(NUM_SAMPLES - 1)) begin
        peak_lift     <= (lift > peak_run) ? lift : peak_run;
        profile_valid <= 1'b1;
        fallback_flag <= !nz;
      end
      if (state == S_RD_MEM) begin
        if ({1'b0, sidx} >= 11'(NUM_SAMPLES)) begin
          o_status <= ST_RANGE;
        end else if (!profile_valid) begin
          o_status <= ST_NOVALID;
        end else if (sidx == 10'd0 || sidx == 10'(NUM_SAMPLES - 1)) begin
          o_value <= '0;
        end else if (peak_lift == '0) begin
          o_value <= ram_rdata[31:0];
        end
      end
      if (state == S_RD_DIV && !div_busy && !div_start) begin
        o_value <= div_q[31:0];
      end
    end
  end

  // compute and read datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_CSUM: begin
        nz       <= coef_any;
        si       <= '0;
        peak_run <= '0;
      end
      S_SIN_WAIT: begin
        s    <= sin_out;
        p    <= sin_out;
        k    <= '0;
        lift <= '0;
      end
      S_HARM: begin
        lift <= lift + 40'(term_prod >> 16);
        p    <= pow_prod[31:16];
        k    <= k + HW'(1);
      end
      S_STORE: begin
        if (lift > peak_run) begin
          peak_run <= lift;
        end
        si <= si + SW'(1);
      end
      S_RD_MEM: begin
        lift  <= ram_rdata;
        phase <= 1'b0;
      end
      S_RD_MUL: begin
        // two partial products, 32x32 low then 8x32 high
        if (!phase) begin
          scaled <= 72'(lift[31:0] * stroke);
          phase  <= 1'b1;
        end else begin
          scaled <= scaled + {40'(lift[39:32] * stroke), 32'd0};
        end
      end
      S_RD_DIV: begin
        // divider starts on the first cycle, once the product is complete
        phase <= 1'b0;
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid = (state == S_OUT);
  assign m_axis_tdata  = {5'd0, fallback_flag, o_status, peak_lift, o_value};

  // a result is only offered while no request can be taken
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("input accepted while result pending");

  // results with an error status never report a value
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && o_status != ST_OK) |-> (o_value == '0))
    else $error("nonzero value with error status");

  // profile becomes valid only at the end of a compute
  assert property (@(posedge clk) disable iff (rst)
    $rose(profile_valid) |-> $past(state) == S_STORE)
    else $error("profile valid set outside compute");
endmodule
`default_nettype wire

### rtl/clpg_ram.sv
// ----------------------------------------------------------------------------
// clpg_ram: generic single-port ram
// one address per cycle, read every cycle and written when we is high, registered read data
// ----------------------------------------------------------------------------
`default_nettype none
module clpg_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 360
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

### rtl/clpg_divider.sv
// ----------------------------------------------------------------------------
// clpg_divider: restoring divider, one quotient bit per cycle
// 73-bit dividend by 64-bit divisor, quotient kept to 73 bits
// ----------------------------------------------------------------------------
`default_nettype none
module clpg_divider (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [72:0] dividend,
  input  wire logic [63:0] divisor,
  output logic             busy,
  output logic      [72:0] quotient
);
  logic [72:0] dvd;
  logic [64:0] rem;
  logic [63:0] dvs;
  logic [6:0]  cnt;
  logic [64:0] shifted;

  assign shifted = {rem[63:0], dvd[72]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy     <= 1'b1;
      cnt      <= 7'd72;
      dvd      <= dividend;
      dvs      <= divisor;
      rem      <= '0;
      quotient <= '0;
    end else if (busy) begin
      dvd <= {dvd[71:0], 1'b0};
      if (shifted >= {1'b0, dvs}) begin
        rem      <= shifted - {1'b0, dvs};
        quotient <= {quotient[71:0], 1'b1};
      end else begin
        rem      <= shifted;
        quotient <= {quotient[71:0], 1'b0};
      end
      if (cnt == '0) begin
        busy <= 1'b0;
      end else begin
        cnt <= cnt - 7'd1;
      end
    end
  end
endmodule
`default_nettype wire

### rtl/clpg_sine.sv
// ----------------------------------------------------------------------------
// clpg_sine: q0.16 sine of pi*i/num_samples by taylor series
// series steps use at most one multiply per cycle, each term divided by (2n)(2n+1) via reciprocal
// ----------------------------------------------------------------------------
`default_nettype none
module clpg_sine
  import clpg_pkg::*;
#(
  parameter int NUM_SAMPLES = NUM_SAMPLES_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  input  wire logic [$clog2(NUM_SAMPLES)-1:0] idx,
  output logic                                busy,
  output logic      [15:0]                    sine
);
  localparam int IW = $clog2(NUM_SAMPLES);
  localparam logic [IW:0] NS = (IW+1)'(NUM_SAMPLES);
  // x = j*q + round((j*r)/ns) with pi_q30 = q*ns + r
  localparam logic [31:0] XQ = 32'(64'(PI_Q30) / 64'(NUM_SAMPLES));
  localparam logic [9:0]  XR = 10'(64'(PI_Q30) % 64'(NUM_SAMPLES));
  localparam logic [28:0] XM =
    29'(((64'd1 << 30) + 64'(NUM_SAMPLES) - 64'd1) / 64'(NUM_SAMPLES));

  typedef enum logic [2:0] {
    Q_IDLE, Q_X, Q_XR, Q_M1, Q_M2, Q_DIV, Q_ACC, Q_FIN
  } sq_t;

  sq_t        st;
  logic [IW:0] j;
  logic [19:0] xr_num;
  logic [31:0] xb;
  logic [48:0] xr_prod;
  logic [33:0] x;
  logic [33:0] t;
  logic [35:0] pos, neg;
  logic [2:0]  n;
  logic [31:0] dnum, dq;
  logic [32:0] drcp;
  logic [5:0]  dsft;
  logic [64:0] dprod;
  logic [67:0] prod;
  logic [35:0] rdiff;
  logic [22:0] rnd;

  assign prod    = t * x;
  assign xr_prod = xr_num * XM;
  assign dprod   = dnum * drcp;
  assign busy = (st != Q_IDLE);
  assign rdiff = (pos > neg) ? pos - neg : '0;
  assign rnd  = 23'((rdiff + 36'd8192) >> 14);

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= Q_IDLE;
    end else begin
      unique case (st)
        Q_IDLE: begin
          if (start) begin
            j    <= ({1'b0, idx} <= NS - {1'b0, idx}) ? {1'b0, idx} : NS - {1'b0, idx};
            st   <= Q_X;
          end
        end
        Q_X: begin
          // x = round(j*pi_q30/ns), split into quotient and remainder parts
          xr_num <= 20'(j) * 20'(XR) + 20'(NUM_SAMPLES / 2);
          xb     <= 32'(j) * XQ;
          st     <= Q_XR;
        end
        Q_XR: begin
          x  <= 34'(xb) + 34'(xr_prod >> 30);
          st <= Q_FIN;
        end
        Q_FIN: begin
          t   <= x;
          pos <= 36'(x);
          neg <= '0;
          n   <= 3'd0;
          st  <= Q_M1;
        end
        Q_M1: begin
          t  <= 34'(prod >> 30);
          st <= Q_M2;
        end
        Q_M2: begin
          dnum <= 32'(prod >> 30);
          drcp <= taylor_recip(n);
          dsft <= taylor_shift(n);
          st   <= Q_DIV;
        end
        Q_DIV: begin
          dq <= 32'(dprod >> dsft);
          st <= Q_ACC;
        end
        Q_ACC: begin
          t <= 34'(dq);
          if (n[0] == 1'b0) begin
            neg <= neg + 36'(dq);
          end else begin
            pos <= pos + 36'(dq);
          end
          if (n == 3'd7) begin
            st <= Q_IDLE;
          end else begin
            n  <= n + 3'd1;
            st <= Q_M1;
          end
        end
        default: st <= Q_IDLE;
      endcase
    end
  end

  assign sine = (rnd > 23'd65535) ? 16'hffff : rnd[15:0];
endmodule
`default_nettype wire

### bench/tb_cam_lift_profile_generator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cam_lift_profile_generator_core: self-checking bench of the cam lift core
// drives clear, load, compute and read transactions, predicts every result
// with a bit-accurate fixed-point lift model, and compares result fields
// ----------------------------------------------------------------------------
module tb_cam_lift_profile_generator_core;
  import clpg_pkg::*;

  localparam int NH = NUM_HARMONICS_DEF;
  localparam int NS = NUM_SAMPLES_DEF;
  localparam longint CYCLE_LIMIT = 4000000;

  typedef struct packed {
    logic [31:0] sample_value;
    logic [39:0] peak_value;
    status_t     status;
    logic        fallback_used;
  } lift_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_data = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [79:0] m_axis_tdata;

  // predictor state
  logic [31:0]     coef_q [NH];
  logic [39:0]     lift_mem [NS];
  logic [39:0]     peak_q;
  logic            profile_ok;
  logic            fallback_q;
  logic [31:0]     stroke_q;
  longint unsigned sine_tab [NS];

  lift_result_t pending_results[$];
  int  err_count   = 0;
  int  sent_count  = 0;
  int  got_count   = 0;
  int  read_count  = 0;
  int  comp_count  = 0;
  int  hold_cycles = 0;
  bit  no_idle     = 1'b0;
  longint cycle_cnt = 0;

  cam_lift_profile_generator_core i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------- model

  // taylor sine to x^17 in q2.30, rounded to q0.16
  function automatic longint unsigned sine_q16(int i);
    longint unsigned j, x, t, pos, neg, r;
    j = (i <= NS - i) ? i : NS - i;
    x = (j * 64'(PI_Q30) + NS / 2) / NS;
    t = x; pos = x; neg = 0;
    for (int n = 1; n <= 8; n++) begin
      t = (t * x) >> 30;
      t = (t * x) >> 30;
      t = t / ((2 * n) * (2 * n + 1));
      if (n % 2 == 1) neg += t;
      else pos += t;
    end
    r = (pos > neg) ? pos - neg : 0;
    r = (r + 8192) >> 14;
    return (r > 65535) ? 65535 : r;
  endfunction

  function automatic void lift_profile_compute();
    longint unsigned amp [NH];
    longint unsigned total, best, s, p, lift;
    total = 0; best = 0;
    for (int k = 0; k < NH; k++) begin
      amp[k] = coef_q[k];
      total += amp[k];
    end
    fallback_q = (total == 0);
    // all-zero store falls back to a unit second harmonic
    if (fallback_q) amp[1] = 64'(ONE_Q16);
    for (int i = 0; i < NS; i++) begin
      s = sine_tab[i];
      p = s; lift = 0;
      for (int k = 0; k < NH; k++) begin
        lift += (amp[k] * p) >> 16;
        p = (p * s) >> 16;
      end
      lift_mem[i] = lift[39:0];
      if (lift[39:0] > best) best = lift[39:0];
    end
    peak_q = best[39:0];
    profile_ok = 1'b1;
  endfunction

  function automatic lift_result_t lift_predict(opcode_t op, logic [4:0] cidx,
                                                logic [31:0] cval, logic [9:0] sidx);
    lift_result_t r;
    logic [127:0] num;
    r.sample_value = '0;
    r.status = ST_OK;
    case (op)
      OP_CLEAR: begin
        foreach (coef_q[k]) coef_q[k] = '0;
      end
      OP_LOAD: begin
        if (cidx >= NH) r.status = ST_RANGE;
        else coef_q[cidx] = cval[31] ? 32'd0 : cval;
      end
      OP_COMPUTE: lift_profile_compute();
      default: begin
        if (sidx >= NS) r.status = ST_RANGE;
        else if (!profile_ok) r.status = ST_NOVALID;
        else if (sidx == 0 || sidx == NS - 1) r.sample_value = '0;
        else if (peak_q == 0) r.sample_value = lift_mem[sidx][31:0];
        else begin
          num = 128'(lift_mem[sidx]) * 128'(stroke_q);
          num = num / 128'(peak_q);
          r.sample_value = num[31:0];
        end
      end
    endcase
    r.peak_value = peak_q;
    r.fallback_used = fallback_q;
    return r;
  endfunction

  // ---------------------------------------------------------------- driving

  task automatic send_item(opcode_t op, logic [4:0] cidx, logic [31:0] cval,
                           logic [9:0] sidx);
    if (!no_idle && $urandom_range(99) < 7) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, sidx, cval, cidx, op};
    do @(posedge clk); while (!s_axis_tready);
    pending_results.push_back(lift_predict(op, cidx, cval, sidx));
    sent_count++;
    if (op == OP_READ) read_count++;
    if (op == OP_COMPUTE) comp_count++;
  endtask

  task automatic wait_drained();
    @(posedge clk);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // stroke write, only while the core is idle
  task automatic write_stroke(logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    stroke_q = value;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
    $display("mismatch at result %0d: %s got %0h want %0h", got_count, field, got, want);
    err_count++;
  endtask

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("tb_cam_lift_profile_generator_core: errors");
      $finish;
    end
  end

  // receiver: random stalls, plus a long hold-off when asked
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles   <= hold_cycles - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= no_idle ? 1'b1 : ($urandom_range(99) >= 7);
    end
  end

  always @(posedge clk) begin
    lift_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $display("unexpected result transaction %0h", m_axis_tdata);
        err_count++;
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tdata[31:0] !== want.sample_value)
          report_mismatch("sample_value", 64'(m_axis_tdata[31:0]), 64'(want.sample_value));
        if (m_axis_tdata[71:32] !== want.peak_value)
          report_mismatch("peak_value", 64'(m_axis_tdata[71:32]), 64'(want.peak_value));
        if (m_axis_tdata[73:72] !== want.status)
          report_mismatch("status", 64'(m_axis_tdata[73:72]), 64'(want.status));
        if (m_axis_tdata[74] !== want.fallback_used)
          report_mismatch("fallback_used", 64'(m_axis_tdata[74]), 64'(want.fallback_used));
      end
      got_count++;
    end
  end

  // ---------------------------------------------------------------- tests

  function automatic logic [31:0] rand_coef();
    case ($urandom_range(3))
      0: return $urandom();
      1: return $urandom_range(32'h0000_ffff);
      default: return $urandom_range(32'h000f_ffff);
    endcase
  endfunction

  function automatic logic [9:0] rand_sample();
    return ($urandom_range(9) == 0) ? 10'($urandom_range(1023)) : 10'($urandom_range(NS - 1));
  endfunction

  // status codes before any profile exists, range checks, extreme loads
  task automatic test_directed();
    send_item(OP_READ, 5'd0, 32'd0, 10'd1023);
    send_item(OP_READ, 5'd0, 32'd0, 10'd5);
    send_item(OP_LOAD, 5'd31, 32'h7fff_ffff, 10'd0);
    send_item(OP_LOAD, 5'd20, 32'h0001_0000, 10'd0);
    send_item(OP_LOAD, 5'd3, 32'h8000_0000, 10'd0);
    send_item(OP_CLEAR, 5'd31, 32'hffff_ffff, 10'h3ff);
    // all zero coefficients: unit second harmonic fallback
    send_item(OP_COMPUTE, 5'd0, 32'd0, 10'd0);
    send_item(OP_READ, 5'd0, 32'd0, 10'd0);
    send_item(OP_READ, 5'd0, 32'd0, 10'(NS - 1));
    send_item(OP_READ, 5'd0, 32'd0, 10'(NS / 2));
    send_item(OP_READ, 5'd0, 32'd0, 10'd1);
    send_item(OP_READ, 5'd0, 32'd0, 10'(NS));
    // tiny top harmonic gives an all-zero profile, unscaled read path
    send_item(OP_LOAD, 5'd19, 32'd1, 10'd0);
    send_item(OP_COMPUTE, 5'd0, 32'd0, 10'd0);
    send_item(OP_READ, 5'd0, 32'd0, 10'd90);
    send_item(OP_READ, 5'd0, 32'd0, 10'(NS - 2));
    // clear keeps the profile
    send_item(OP_CLEAR, 5'd0, 32'd0, 10'd0);
    send_item(OP_READ, 5'd0, 32'd0, 10'd45);
    wait_drained();
  endtask

  // full-scale coefficients, reads at both stroke extremes
  task automatic test_stroke_extremes();
    for (int k = 0; k < NH; k++) send_item(OP_LOAD, 5'(k), 32'h7fff_ffff, 10'd0);
    send_item(OP_COMPUTE, 5'd0, 32'd0, 10'd0);
    wait_drained();
    for (int pass = 0; pass < 3; pass++) begin
      write_stroke(pass == 0 ? 32'hffff_ffff : (pass == 1 ? 32'd0 : 32'd1));
      repeat (15) send_item(OP_READ, 5'd0, 32'd0, rand_sample());
      wait_drained();
    end
  endtask

  // receiver stalls long while reads keep coming
  task automatic test_backpressure();
    write_stroke($urandom());
    hold_cycles = 400;
    repeat (12) send_item(OP_READ, 5'd0, 32'd0, rand_sample());
    wait_drained();
  endtask

  // phases of loads, a few computes, many reads with noise in between
  task automatic test_random();
    for (int ph = 0; ph < 5; ph++) begin
      write_stroke(ph == 4 ? 32'd655360 : $urandom());
      no_idle = (ph == 2);
      if ($urandom_range(1)) send_item(OP_CLEAR, 5'($urandom()), $urandom(), 10'($urandom()));
      repeat (25) send_item(OP_LOAD, 5'($urandom_range(NH + 3)), rand_coef(),
                            10'($urandom()));
      if (ph == 1 || ph == 3) send_item(OP_COMPUTE, 5'($urandom()), $urandom(), 10'($urandom()));
      for (int n = 0; n < 135; n++) begin
        case ($urandom_range(19))
          0: send_item(OP_LOAD, 5'($urandom()), $urandom(), 10'($urandom()));
          1: send_item(OP_CLEAR, 5'($urandom()), $urandom(), 10'($urandom()));
          default: send_item(OP_READ, 5'($urandom()), $urandom(), rand_sample());
        endcase
      end
      wait_drained();
    end
    no_idle = 1'b0;
  endtask

  initial begin
    int drain;
    foreach (coef_q[k]) coef_q[k] = '0;
    foreach (lift_mem[i]) lift_mem[i] = '0;
    for (int i = 0; i < NS; i++) sine_tab[i] = sine_q16(i);
    peak_q = '0;
    profile_ok = 1'b0;
    fallback_q = 1'b0;
    stroke_q = STROKE_RESET;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_stroke_extremes();
    test_backpressure();
    test_random();

    drain = 0;
    while (pending_results.size() != 0 && drain < 200000) begin
      @(posedge clk);
      drain++;
    end
    repeat (100) @(posedge clk);
    $display("%0d transactions sent, %0d results checked", sent_count, got_count);
    $display("%0d sample reads over %0d profile computes, stroke extremes and stalls",
             read_count, comp_count);
    if (err_count == 0 && pending_results.size() == 0) begin
      $display("tb_cam_lift_profile_generator_core: clean");
    end else begin
      $display("tb_cam_lift_profile_generator_core: errors");
    end
    $finish;
  end

endmodule
